FILE: rtl/core/ssa_pkg.sv
package ssa_pkg;

	localparam int DEF_NUM_SLOTS       = 256;
	localparam int DEF_USE_COUNT_WIDTH = 16;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b1;

	localparam logic [1:0] ACT_FIND    = 2'd0;
	localparam logic [1:0] ACT_ALLOC   = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;
	localparam logic [1:0] ACT_READ    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_BAD      = 2'd2;
	localparam logic [1:0] ST_CONFLICT = 2'd3;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;
	localparam logic [1:0] FIT_LAST  = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [8:0] slot_count;
		logic [7:0] first_slot;
		logic [7:0] last_slot;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  fit_start;
		logic [7:0]  fit_end;
		logic        slot_busy_bit;
		logic [15:0] slot_uses;
		logic [8:0]  free_slots;
		logic [8:0]  largest_free_run;
		logic [7:0]  free_run_count;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic check_start;
		logic scan_start;
	} ssa_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic clearing;
		logic need_check;
		logic check_done;
		logic scan_done;
	} ssa_stat_t;

endpackage

FILE: rtl/core/spectrum_slot_allocator.sv
// Contiguous spectrum slot allocator. Each item finds a free run of slots under the
// configured fit policy, allocates or releases a slot range, or reads one slot, and
// every result carries the free-slot count, the longest free run and the number of
// free runs. All work goes through one slot memory, one slot per cycle: each item scans
// all n managed slots, and an allocate or release with a good range first runs a check
// pass over first_slot to last_slot. A new item is taken while the previous result
// still waits on the output register. After reset a clearing pass writes every slot
// to zero before the first item is taken; configuration writes are taken at any time
// the block is idle.
module spectrum_slot_allocator import ssa_pkg::*; #(
	parameter int NUM_SLOTS       = DEF_NUM_SLOTS,
	parameter int USE_COUNT_WIDTH = DEF_USE_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp
);

	ssa_cmd_t  cmd;
	ssa_stat_t stat;
	rsp_t      dp_rsp;
	logic      rsp_load;
	logic      rsp_free;
	logic      rsp_valid_q;
	rsp_t      rsp_q;

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	ssa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.rsp_free  (rsp_free),
		.cmd       (cmd),
		.rsp_load  (rsp_load)
	);

	ssa_dpath #(
		.NUM_SLOTS       (NUM_SLOTS),
		.USE_COUNT_WIDTH (USE_COUNT_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (dp_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) rsp_q <= dp_rsp;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: rtl/core/ssa_ctrl.sv
module ssa_ctrl import ssa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  ssa_stat_t stat,
	input  logic      rsp_free,
	output ssa_cmd_t  cmd,
	output logic      rsp_load
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECODE = 3'd2;
	localparam logic [2:0] S_CHECK  = 3'd3;
	localparam logic [2:0] S_START  = 3'd4;
	localparam logic [2:0] S_SCAN   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_next;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		rsp_load   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				if (!stat.clearing) state_next = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load   = 1'b1;
					state_next = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.need_check) begin
					cmd.check_start = 1'b1;
					state_next      = S_CHECK;
				end else begin
					cmd.scan_start = 1'b1;
					state_next     = S_SCAN;
				end
			end
			S_CHECK: begin
				if (stat.check_done) state_next = S_START;
			end
			S_START: begin
				cmd.scan_start = 1'b1;
				state_next     = S_SCAN;
			end
			S_SCAN: begin
				if (stat.scan_done) state_next = S_FINISH;
			end
			S_FINISH: begin
				if (rsp_free) begin
					rsp_load   = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	a_load_to_decode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_DECODE)
		else $error("accepted item did not move to decode");

	a_check_done_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		stat.check_done |-> state_q == S_CHECK)
		else $error("range check finished outside the check state");

	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		stat.scan_done |-> state_q == S_SCAN)
		else $error("slot scan finished outside the scan state");

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> req_stall)
		else $error("item accepted during the clearing pass");

	a_result_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> rsp_free)
		else $error("result loaded over a waiting result");

endmodule

FILE: rtl/core/ssa_dpath.sv
module ssa_dpath import ssa_pkg::*; #(
	parameter int NUM_SLOTS       = DEF_NUM_SLOTS,
	parameter int USE_COUNT_WIDTH = DEF_USE_COUNT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  req_t                  req,
	input  ssa_cmd_t              cmd,
	output ssa_stat_t             stat,
	output rsp_t                  rsp
);

	localparam int IDX_W = $clog2(NUM_SLOTS);
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int CMP_W = (CNT_W > 9) ? CNT_W + 1 : 10;
	localparam int UCW   = USE_COUNT_WIDTH;

	// Slot memory: busy bit on top of the use counter.
	logic [UCW:0] mem [NUM_SLOTS];

	logic [1:0] fit_policy_q;
	logic [8:0] slots_in_use_q;

	logic [1:0] act_q;
	logic [8:0] w_q;
	logic [7:0] a_q;
	logic [7:0] b_q;
	logic [1:0] status_q;

	logic             clr_q;
	logic [IDX_W-1:0] clr_ptr_q;

	logic             iss_q;
	logic             scan_q;
	logic             upd_q;
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] end_q;

	logic             v_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [UCW:0]     rd_s1;

	logic             any_busy_q;
	logic [CNT_W-1:0] len_q;
	logic [IDX_W-1:0] rs_q;
	logic [CNT_W-1:0] nfree_q;
	logic [CNT_W-1:0] largest_q;
	logic [7:0]       runs_q;
	logic             found_q;
	logic [CNT_W-1:0] best_len_q;
	logic [IDX_W-1:0] best_s_q;
	logic             rb_q;
	logic [15:0]      ru_q;

	logic [CMP_W-1:0] n_c;
	logic [CMP_W-1:0] req_w_c;
	logic [CMP_W-1:0] req_a_c;
	logic [CMP_W-1:0] req_b_c;
	logic [1:0]       load_status;

	always_comb begin
		if (slots_in_use_q == 9'd0) begin
			n_c = CMP_W'(1);
		end else if (CMP_W'(slots_in_use_q) > CMP_W'(NUM_SLOTS)) begin
			n_c = CMP_W'(NUM_SLOTS);
		end else begin
			n_c = CMP_W'(slots_in_use_q);
		end
	end

	assign req_w_c = CMP_W'(req.slot_count);
	assign req_a_c = CMP_W'(req.first_slot);
	assign req_b_c = CMP_W'(req.last_slot);

	always_comb begin
		load_status = ST_OK;
		case (req.action)
			ACT_FIND: begin
				if (req_w_c == '0) load_status = ST_BAD;
			end
			ACT_ALLOC, ACT_RELEASE: begin
				if (req_a_c > req_b_c || req_b_c >= n_c) load_status = ST_BAD;
			end
			default: begin
				if (req_a_c >= n_c) load_status = ST_BAD;
			end
		endcase
	end

	logic range_op;
	assign range_op = (act_q == ACT_ALLOC) || (act_q == ACT_RELEASE);

	// Stage one: data read from the memory in the previous cycle.
	logic             busy_old;
	logic [UCW-1:0]   uses_old;
	logic [UCW-1:0]   uses_inc;
	logic             in_rng;
	logic             busy_new;
	logic             check_last;
	logic             scan_last;
	logic             any_busy_all;
	logic [CMP_W-1:0] idx_c;
	logic [31:0]      uses32;

	assign busy_old     = rd_s1[UCW];
	assign uses_old     = rd_s1[UCW-1:0];
	assign uses_inc     = (&uses_old) ? uses_old : uses_old + UCW'(1);
	assign idx_c        = CMP_W'(idx_s1);
	assign in_rng       = upd_q && idx_c >= CMP_W'(a_q) && idx_c <= CMP_W'(b_q);
	assign busy_new     = in_rng ? (act_q == ACT_ALLOC) : busy_old;
	assign check_last   = v_s1 && !scan_q && last_s1;
	assign scan_last    = v_s1 && scan_q && last_s1;
	assign any_busy_all = any_busy_q || busy_old;
	assign uses32       = 32'(uses_old);

	// The run that closes at this slot: at a busy slot or at the last managed slot.
	logic             run_ends;
	logic [CNT_W-1:0] run_len;
	logic [IDX_W-1:0] run_start;
	logic             take;
	logic [CMP_W-1:0] last_fit_c;

	always_comb begin
		run_ends  = v_s1 && scan_q && (busy_new || last_s1);
		run_len   = len_q;
		run_start = rs_q;
		if (!busy_new) begin
			run_len   = len_q + CNT_W'(1);
			run_start = (len_q == '0) ? idx_s1 : rs_q;
		end
		last_fit_c = CMP_W'(run_start) + CMP_W'(run_len) - CMP_W'(w_q);
		take = 1'b0;
		if (run_ends && CMP_W'(run_len) >= CMP_W'(w_q) && run_len != '0) begin
			case (fit_policy_q)
				FIT_FIRST: take = !found_q;
				FIT_BEST:  take = !found_q || run_len < best_len_q;
				FIT_WORST: take = !found_q || run_len > best_len_q;
				default:   take = 1'b1;
			endcase
		end
	end

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [UCW:0]     wr_data;

	always_comb begin
		if (clr_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_ptr_q;
			wr_data = '0;
		end else begin
			wr_en   = v_s1 && scan_q && in_rng;
			wr_addr = idx_s1;
			if (act_q == ACT_ALLOC) begin
				wr_data = {1'b1, uses_inc};
			end else begin
				wr_data = {1'b0, uses_old};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (iss_q) rd_s1 <= mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q   <= FIT_FIRST;
			slots_in_use_q <= 9'(DEF_NUM_SLOTS);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FIT_POLICY:   fit_policy_q   <= cfg_wdata[1:0];
				REG_SLOTS_IN_USE: slots_in_use_q <= cfg_wdata[8:0];
				default:          fit_policy_q   <= fit_policy_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_ptr_q <= '0;
		end else if (clr_q) begin
			clr_ptr_q <= clr_ptr_q + IDX_W'(1);
			if (clr_ptr_q == IDX_W'(NUM_SLOTS - 1)) clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= ACT_FIND;
			w_q      <= '0;
			a_q      <= '0;
			b_q      <= '0;
			status_q <= ST_OK;
			iss_q    <= 1'b0;
			scan_q   <= 1'b0;
			upd_q    <= 1'b0;
			ptr_q    <= '0;
			end_q    <= '0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			idx_s1   <= '0;
		end else begin
			if (cmd.load) begin
				act_q    <= req.action;
				w_q      <= req.slot_count;
				a_q      <= req.first_slot;
				b_q      <= req.last_slot;
				status_q <= load_status;
			end
			if (check_last) begin
				if ((act_q == ACT_ALLOC && any_busy_all) ||
				    (act_q == ACT_RELEASE && !any_busy_all)) begin
					status_q <= ST_CONFLICT;
				end
			end

			v_s1    <= iss_q;
			idx_s1  <= ptr_q;
			last_s1 <= iss_q && (ptr_q == end_q);
			if (cmd.check_start) begin
				iss_q  <= 1'b1;
				scan_q <= 1'b0;
				ptr_q  <= IDX_W'(a_q);
				end_q  <= IDX_W'(b_q);
			end else if (cmd.scan_start) begin
				iss_q  <= 1'b1;
				scan_q <= 1'b1;
				upd_q  <= range_op && status_q == ST_OK;
				ptr_q  <= '0;
				end_q  <= IDX_W'(n_c - CMP_W'(1));
			end else if (iss_q) begin
				if (ptr_q == end_q) iss_q <= 1'b0;
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_busy_q <= 1'b0;
			len_q      <= '0;
			rs_q       <= '0;
			nfree_q    <= '0;
			largest_q  <= '0;
			runs_q     <= '0;
			found_q    <= 1'b0;
			best_len_q <= '0;
			best_s_q   <= '0;
			rb_q       <= 1'b0;
			ru_q       <= '0;
		end else begin
			if (cmd.check_start) begin
				any_busy_q <= 1'b0;
			end else if (v_s1 && !scan_q) begin
				any_busy_q <= any_busy_all;
			end

			if (cmd.scan_start) begin
				len_q     <= '0;
				nfree_q   <= '0;
				largest_q <= '0;
				runs_q    <= '0;
				found_q   <= 1'b0;
			end else if (v_s1 && scan_q) begin
				if (!busy_new) begin
					nfree_q <= nfree_q + CNT_W'(1);
					len_q   <= len_q + CNT_W'(1);
					if (len_q == '0) begin
						rs_q <= idx_s1;
						if (runs_q != 8'hFF) runs_q <= runs_q + 8'd1;
					end
					if (len_q + CNT_W'(1) > largest_q) largest_q <= len_q + CNT_W'(1);
				end else begin
					len_q <= '0;
				end
				if (take) begin
					found_q    <= 1'b1;
					best_len_q <= run_len;
					if (fit_policy_q == FIT_LAST) begin
						best_s_q <= last_fit_c[IDX_W-1:0];
					end else begin
						best_s_q <= run_start;
					end
				end
				if (idx_c == CMP_W'(a_q)) begin
					rb_q <= busy_old;
					ru_q <= (uses32 > 32'd65535) ? 16'hFFFF : uses32[15:0];
				end
			end
		end
	end

	logic             find_ok;
	logic             read_ok;
	logic [CMP_W-1:0] fit_end_c;
	logic [CMP_W-1:0] nfree_c;
	logic [CMP_W-1:0] largest_c;

	assign find_ok   = act_q == ACT_FIND && status_q == ST_OK && found_q;
	assign read_ok   = act_q == ACT_READ && status_q == ST_OK;
	assign fit_end_c = CMP_W'(best_s_q) + CMP_W'(w_q) - CMP_W'(1);
	assign nfree_c   = CMP_W'(nfree_q);
	assign largest_c = CMP_W'(largest_q);

	always_comb begin
		rsp.status = status_q;
		if (act_q == ACT_FIND && status_q == ST_OK && !found_q) rsp.status = ST_NOFIT;
		rsp.fit_start     = find_ok ? 8'(CMP_W'(best_s_q)) : 8'd0;
		rsp.fit_end       = find_ok ? fit_end_c[7:0] : 8'd0;
		rsp.slot_busy_bit = read_ok ? rb_q : 1'b0;
		rsp.slot_uses     = read_ok ? ru_q : 16'd0;
		rsp.free_slots       = (nfree_c > CMP_W'(9'h1FF)) ? 9'h1FF : nfree_c[8:0];
		rsp.largest_free_run = (largest_c > CMP_W'(9'h1FF)) ? 9'h1FF : largest_c[8:0];
		rsp.free_run_count   = runs_q;
	end

	assign stat.clearing   = clr_q;
	assign stat.need_check = range_op && status_q == ST_OK;
	assign stat.check_done = check_last;
	assign stat.scan_done  = scan_last;

endmodule
